/* rtl/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/pprr_pkg.sv */
`timescale 1ns / 1ps

package pprr_pkg;

  // input function codes
  localparam logic FUNC_ARRIVAL = 1'b0;
  localparam logic FUNC_TICK    = 1'b1;

  // dispatch codes
  localparam logic [1:0] DISP_NONE   = 2'd0;
  localparam logic [1:0] DISP_FIRST  = 2'd1;
  localparam logic [1:0] DISP_RESUME = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;

  localparam logic [3:0] SLICE_RESET = 4'd3;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_POP
  } q_op_e;

  typedef struct packed {
    logic [7:0]  id;
    logic [3:0]  prio;
    logic [15:0] burst;
    logic        started;
  } task_ent_t;

  typedef struct packed {
    q_op_e     op;
    task_ent_t ent;
  } q_cmd_t;

  typedef struct packed {
    logic        func;
    logic [7:0]  task_id;
    logic [3:0]  task_priority;
    logic [15:0] task_burst;
  } in_item_t;

  typedef struct packed {
    logic       running_valid;
    logic [7:0] running_task;
    logic [1:0] dispatch;
    logic       stopped_valid;
    logic [7:0] stopped_task;
    logic       finished_valid;
    logic [1:0] status;
    logic [4:0] queue_count;
  } out_item_t;

endpackage

/* rtl/pprr_cell.sv */
`timescale 1ns / 1ps

module pprr_cell (
  input  logic               clk_i,
  input  pprr_pkg::q_cmd_t   cmd_i,
  input  logic               occ_i,
  input  logic               left_stay_i,
  input  pprr_pkg::task_ent_t left_ent_i,
  input  pprr_pkg::task_ent_t right_ent_i,
  output pprr_pkg::task_ent_t ent_o,
  output logic               stay_o
);
  import pprr_pkg::*;

  task_ent_t ent_q, ent_d;

  // entry keeps its place on insert if it is at least as urgent as the new one
  assign stay_o = occ_i && (ent_q.prio <= cmd_i.ent.prio);
  assign ent_o  = ent_q;

  always_comb begin
    ent_d = ent_q;
    unique case (cmd_i.op)
      OP_INSERT: begin
        if (stay_o) begin
          ent_d = ent_q;
        end else if (left_stay_i) begin
          ent_d = cmd_i.ent;
        end else begin
          ent_d = left_ent_i;
        end
      end
      OP_POP:  ent_d = right_ent_i;
      OP_HOLD: ent_d = ent_q;
      default: ent_d = ent_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

endmodule

/* rtl/pprr_queue.sv */
`timescale 1ns / 1ps

module pprr_queue #(
  parameter int Depth = 16,
  parameter int CntW  = 5
) (
  input  logic                clk_i,
  input  pprr_pkg::q_cmd_t    cmd_i,
  input  logic [CntW-1:0]     count_i,
  output pprr_pkg::task_ent_t head_o
);
  import pprr_pkg::*;

  task_ent_t ent  [Depth];
  logic      stay [Depth];

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic      occ;
    logic      left_stay;
    task_ent_t left_ent;
    task_ent_t right_ent;

    assign occ = CntW'(i) < count_i;

    if (i == 0) begin : g_first
      assign left_stay = 1'b1;
      assign left_ent  = cmd_i.ent;
    end else begin : g_mid
      assign left_stay = stay[i-1];
      assign left_ent  = ent[i-1];
    end

    if (i == Depth - 1) begin : g_last
      assign right_ent = ent[i];
    end else begin : g_inner
      assign right_ent = ent[i+1];
    end

    pprr_cell u_cell (
      .clk_i       (clk_i),
      .cmd_i       (cmd_i),
      .occ_i       (occ),
      .left_stay_i (left_stay),
      .left_ent_i  (left_ent),
      .right_ent_i (right_ent),
      .ent_o       (ent[i]),
      .stay_o      (stay[i])
    );
  end

  assign head_o = ent[0];

endmodule

/* rtl/preemptive_priority_rr_scheduler_unit.sv */
`timescale 1ns / 1ps
// Output: the result item is in the output register the cycle after the item is taken.
// Throughput: input is held while a result waits unread and while a displaced task is
//   re-inserted: the ready queue does one shift pass per cycle (pop, then re-insert).
// Reset: queue empty, CPU idle, slice counter and slice length 3, no result pending.
//   Queue cell contents are not cleared; only cells below the fill count are read.

module preemptive_priority_rr_scheduler_unit #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  pprr_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output pprr_pkg::out_item_t out_item_o,
  input  logic               cfg_we_i,
  input  logic [3:0]         cfg_data_i
);
  import pprr_pkg::*;

  `include "assert_macros.svh"

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    S_IDLE,
    S_REINS
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;      // ready queue fill count
  logic             cur_v_q, cur_v_d;  // CPU busy
  task_ent_t        cur_q, cur_d;      // running task
  task_ent_t        reins_q, reins_d;  // displaced task waiting for re-insert
  logic [3:0]       slice_q, slice_d;
  logic [3:0]       slice_len_q;
  logic             out_v_q, out_v_d;
  out_item_t        out_q, out_d;

  q_cmd_t           cmd;
  task_ent_t        head;

  // tick decode
  logic             take, stop, run_v, fin;
  task_ent_t        run_ent;
  logic [15:0]      burst_n;
  logic [3:0]       slice_base;
  logic [CNT_W-1:0] cnt_fin;
  logic             full;
  logic             acc;

  assign acc        = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE) && (!out_v_q || out_ready_i);
  assign full       = (cnt_q == CNT_W'(QUEUE_DEPTH));

  pprr_queue #(
    .Depth (QUEUE_DEPTH),
    .CntW  (CNT_W)
  ) u_queue (
    .clk_i   (clk_i),
    .cmd_i   (cmd),
    .count_i (cnt_q),
    .head_o  (head)
  );

  // head may take the CPU: idle, more urgent, or equal once the slice is spent
  always_comb begin
    take = 1'b0;
    if (cnt_q != '0) begin
      if (!cur_v_q) begin
        take = 1'b1;
      end else if (head.prio < cur_q.prio) begin
        take = 1'b1;
      end else if ((head.prio == cur_q.prio) && (slice_q == 4'd0)) begin
        take = 1'b1;
      end
    end
    stop       = take && cur_v_q;
    run_ent    = take ? head : cur_q;
    run_v      = take || cur_v_q;
    burst_n    = run_ent.burst - {15'd0, (run_ent.burst != 16'd0)};
    fin        = run_v && (burst_n == 16'd0);
    slice_base = take ? slice_len_q : slice_q;
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cur_v_d = cur_v_q;
    cur_d   = cur_q;
    reins_d = reins_q;
    slice_d = slice_q;
    out_v_d = out_v_q && !out_ready_i;
    out_d   = out_q;
    cnt_fin = cnt_q;
    cmd.op  = OP_HOLD;
    cmd.ent = reins_q;

    unique case (state_q)
      S_REINS: begin
        // second pass: displaced task goes back after its equal-priority peers
        cmd.op  = OP_INSERT;
        cmd.ent = reins_q;
        cnt_d   = cnt_q + CNT_W'(1);
        state_d = S_IDLE;
      end
      S_IDLE: begin
        if (acc) begin
          out_v_d = 1'b1;
          out_d   = '0;
          if (in_item_i.func == FUNC_ARRIVAL) begin
            cmd.ent.id      = in_item_i.task_id;
            cmd.ent.prio    = in_item_i.task_priority;
            cmd.ent.burst   = in_item_i.task_burst;
            cmd.ent.started = 1'b0;
            if (in_item_i.task_burst == 16'd0) begin
              out_d.status = ST_ZERO;
            end else if (full) begin
              out_d.status = ST_FULL;
            end else begin
              cmd.op = OP_INSERT;
              cnt_d  = cnt_q + CNT_W'(1);
            end
            cnt_fin = cnt_d;
          end else begin
            if (take) begin
              cmd.op = OP_POP;
              cnt_d  = cnt_q - CNT_W'(1);
              out_d.dispatch = head.started ? DISP_RESUME : DISP_FIRST;
            end
            if (stop) begin
              reins_d = cur_q;
              state_d = S_REINS;
              out_d.stopped_valid = 1'b1;
              out_d.stopped_task  = cur_q.id;
              cnt_fin = cnt_q;  // pop and re-insert cancel out
            end else begin
              cnt_fin = cnt_d;
            end
            out_d.running_valid  = run_v;
            out_d.running_task   = run_v ? run_ent.id : 8'd0;
            out_d.finished_valid = fin;
            cur_d         = run_ent;
            cur_d.burst   = burst_n;
            cur_d.started = 1'b1;
            cur_v_d       = run_v && !fin;
            slice_d       = slice_base - {3'd0, (slice_base != 4'd0)};
          end
          out_d.queue_count = 5'(cnt_fin);
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      cur_v_q     <= 1'b0;
      slice_q     <= SLICE_RESET;
      slice_len_q <= SLICE_RESET;
      out_v_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      cur_v_q <= cur_v_d;
      slice_q <= slice_d;
      out_v_q <= out_v_d;
      if (cfg_we_i) begin
        slice_len_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    reins_q <= reins_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

  `ASSERT_IMPL(a_cnt_max, 1'b1, cnt_q <= CNT_W'(QUEUE_DEPTH))
  `ASSERT_NEXT(a_reins_once, state_q == S_REINS, state_q == S_IDLE)
  `ASSERT_IMPL(a_reins_blocks, state_q == S_REINS, !in_ready_o)
  `ASSERT_IMPL(a_fin_runs, out_v_q && out_q.finished_valid, out_q.running_valid)
  `ASSERT_NEXT(a_stop_reins, acc && (in_item_i.func == FUNC_TICK) && stop,
               state_q == S_REINS)

endmodule
